// ===== hdl/tuner_preset_controller_macros.svh =====
// assertion macros for the tuner preset controller
// used by the top level; expects clk and rst_n in scope
`ifndef TUNER_PRESET_CONTROLLER_MACROS_SVH
`define TUNER_PRESET_CONTROLLER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TPC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tuner preset controller: same-cycle check failed");

`define TPC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tuner preset controller: next-cycle check failed");

`else

`define TPC_ASSERT_IMP(label, ante, cons)

`define TPC_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== hdl/tpc_pkg.sv =====
// shared types and constants of the tuner preset controller
// no dependencies; imported by the top level, front end, queue and back end
`default_nettype none

package tpc_pkg;

    // command opcodes as they arrive on the command channel
    localparam logic [2:0] OPC_DOWN   = 3'd0;
    localparam logic [2:0] OPC_UP     = 3'd1;
    localparam logic [2:0] OPC_NEXT   = 3'd2;
    localparam logic [2:0] OPC_PREV   = 3'd3;
    localparam logic [2:0] OPC_STORE  = 3'd4;
    localparam logic [2:0] OPC_RECALL = 3'd5;
    localparam logic [2:0] OPC_MUTE   = 3'd6;
    localparam logic [2:0] OPC_STATUS = 3'd7;

    // configuration register indexes
    localparam logic [2:0] CFG_FREQ_BOTTOM   = 3'd0;
    localparam logic [2:0] CFG_FREQ_TOP      = 3'd1;
    localparam logic [2:0] CFG_STATION_COUNT = 3'd2;
    localparam logic [2:0] CFG_FIRST_MODE    = 3'd3;
    localparam logic [2:0] CFG_SECOND_MODE   = 3'd4;
    localparam logic [2:0] CFG_MUTE_BYTE     = 3'd5;
    localparam logic [2:0] CFG_READ_MODE     = 3'd6;

    // fixed frame bytes
    localparam logic [7:0] FREQ_D3 = 8'h41;
    localparam logic [7:0] CTRL_D1 = 8'h57;
    localparam logic [7:0] CTRL_D2 = 8'hA8;
    localparam logic [7:0] CTRL_D3 = 8'h28;

    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // slot field wide enough for the largest store
    localparam int SLOT_W = 6;

    typedef enum logic [2:0] {
        OP_DOWN,
        OP_UP,
        OP_STORE,
        OP_RECALL,
        OP_MUTE,
        OP_STATUS
    } op_t;

    typedef enum logic [1:0] {
        BK_HEAD,
        BK_READ,
        BK_SECOND
    } bk_state_t;

    typedef struct packed {
        logic [15:0] freq_bottom;
        logic [15:0] freq_top;
        logic [5:0]  station_count;
        logic [7:0]  first_mode;
        logic [7:0]  second_mode;
        logic [7:0]  mute_byte;
        logic [7:0]  read_mode;
    } cfg_t;

    typedef struct packed {
        op_t              op;
        logic [SLOT_W-1:0] slot;
        logic             oob;
        logic [23:0]      rx_data;
    } q_entry_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  mode_byte;
        logic [7:0]  data_one;
        logic [7:0]  data_two;
        logic [7:0]  data_three;
        logic        last;
        logic [3:0]  indicators;
        logic [23:0] if_count;
        logic [15:0] frequency;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/tpc_if.sv =====
// channel interfaces of the tuner preset controller: command, response, config
// no dependencies
`default_nettype none

interface tpc_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [5:0]  station;
    logic [23:0] rx_data;

    modport source (output valid, output opcode, output station, output rx_data,
                    input ready);
    modport sink (input valid, input opcode, input station, input rx_data,
                  output ready);
endinterface

interface tpc_rsp_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  mode_byte;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [7:0]  data_three;
    logic        last;
    logic [3:0]  indicators;
    logic [23:0] if_count;
    logic [15:0] frequency;

    modport source (output valid, output kind, output mode_byte, output data_one,
                    output data_two, output data_three, output last,
                    output indicators, output if_count, output frequency,
                    input ready);
    modport sink (input valid, input kind, input mode_byte, input data_one,
                  input data_two, input data_three, input last,
                  input indicators, input if_count, input frequency,
                  output ready);
endinterface

interface tpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/tuner_preset_controller.sv =====
// top level of the tuner preset controller: config registers, front end, queue, back end
// depends on tpc_pkg, tpc_if, tpc_front, tpc_queue, tpc_back and the macros header
//
//   channel | modport | moves
//   --------+---------+-----------------------------------------------
//   cmd     | sink    | one command: opcode, station, rx_data
//   rsp     | source  | one frame or status report per transaction
//   cfg     | sink    | one register write: index, data (always ready)
//
// step or tune commands pass the back-end head and second-frame states, one frame
// each; next, prev and recall also pass the read state, the registered read of
// the preset ram. store, wraps without a frame, mute and status end in the head
// state; recall of slot zero is dropped in the front end.
// the front end takes a command every cycle while the two-entry queue has room.
// the output register holds a frame until taken; steps that emit one stall meanwhile.
// reset clears the preset store at once through per-slot valid bits, no sweep.
`default_nettype none
`include "tuner_preset_controller_macros.svh"

module tuner_preset_controller
    import tpc_pkg::*;
#(
    parameter int PRESET_SLOTS = 32,
    parameter int FREQ_STEP    = 10
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tpc_cmd_if.sink   cmd,
    tpc_rsp_if.source rsp,
    tpc_cfg_if.sink   cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     q_push;
    q_entry_t q_entry;
    logic     q_full;
    logic     q_pop;
    q_entry_t q_head;
    logic     q_head_valid;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FREQ_BOTTOM:   cfg_next.freq_bottom   = cfg.data;
                CFG_FREQ_TOP:      cfg_next.freq_top      = cfg.data;
                CFG_STATION_COUNT: cfg_next.station_count = cfg.data[5:0];
                CFG_FIRST_MODE:    cfg_next.first_mode    = cfg.data[7:0];
                CFG_SECOND_MODE:   cfg_next.second_mode   = cfg.data[7:0];
                CFG_MUTE_BYTE:     cfg_next.mute_byte     = cfg.data[7:0];
                CFG_READ_MODE:     cfg_next.read_mode     = cfg.data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.freq_bottom   <= 16'd8750;
            cfg_reg.freq_top      <= 16'd10800;
            cfg_reg.station_count <= 6'd30;
            cfg_reg.first_mode    <= 8'd0;
            cfg_reg.second_mode   <= 8'd0;
            cfg_reg.mute_byte     <= 8'd0;
            cfg_reg.read_mode     <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tpc_front #(
        .PRESET_SLOTS (PRESET_SLOTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .station_count (cfg_reg.station_count),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    tpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid)
    );

    tpc_back #(
        .PRESET_SLOTS (PRESET_SLOTS),
        .FREQ_STEP    (FREQ_STEP)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (q_head),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .rsp        (rsp)
    );

    // the control frame comes right after a taken frequency frame
    `TPC_ASSERT_NXT(a_tune_pair, rsp.valid && rsp.ready && !rsp.last, rsp.valid && rsp.last && rsp.data_one == CTRL_D1)
    `TPC_ASSERT_IMP(a_first_tag, rsp.valid && !rsp.last, rsp.kind == KIND_FRAME && rsp.data_three == FREQ_D3)
    `TPC_ASSERT_IMP(a_frame_clean, rsp.valid && rsp.kind == KIND_FRAME, rsp.if_count == 24'd0 && rsp.indicators == 4'd0)
    `TPC_ASSERT_IMP(a_status_fields, rsp.valid && rsp.kind == KIND_STATUS, rsp.last && rsp.indicators == rsp.if_count[23:20])

endmodule

`default_nettype wire

// ===== hdl/tpc_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire logic [WIDTH-1:0]      wr_data,
    input  wire logic                  rd_en,
    input  wire logic [AW-1:0]         rd_addr,
    output logic      [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/tpc_queue.sv =====
// two-entry command queue between front end and back end
// depends on tpc_pkg
`default_nettype none

module tpc_queue
    import tpc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t push_data,
    output logic          full,
    input  wire logic     pop,
    output q_entry_t      head,
    output logic          head_valid
);

    q_entry_t    entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tpc_front.sv =====
// front end: accepts commands, keeps the preset number, classifies into queue entries
// depends on tpc_pkg and tpc_cmd_if
`default_nettype none

module tpc_front
    import tpc_pkg::*;
#(
    parameter int PRESET_SLOTS = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    tpc_cmd_if.sink         cmd,
    input  wire logic [5:0] station_count,
    input  wire logic       q_full,
    output logic            q_push,
    output q_entry_t        q_entry
);

    localparam int PW = $clog2(PRESET_SLOTS + 1);
    localparam int CW = (PW > 6) ? PW : 6;

    logic [PW-1:0] preset_reg;
    logic [PW-1:0] preset_next;
    logic [CW-1:0] cnt_w;
    logic [CW-1:0] slots_w;
    logic [CW-1:0] preset_w;
    logic [CW-1:0] adv_w;
    logic [CW-1:0] prv_w;
    logic [CW-1:0] slot_n;
    logic          accept;
    logic          drop;
    op_t           op;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        cnt_w    = CW'(station_count);
        preset_w = CW'(preset_reg);
        if (cnt_w == '0)
        begin
            slots_w = CW'(1);
        end
        else if (cnt_w > CW'(PRESET_SLOTS))
        begin
            slots_w = CW'(PRESET_SLOTS);
        end
        else
        begin
            slots_w = cnt_w;
        end
        adv_w = (preset_w < slots_w) ? preset_w + CW'(1) : CW'(1);
        prv_w = (preset_w > CW'(1)) ? preset_w - CW'(1) : CW'(1);
    end

    always_comb
    begin
        op          = OP_STATUS;
        slot_n      = CW'(1);
        drop        = 1'b0;
        preset_next = preset_reg;
        case (cmd.opcode)
            OPC_DOWN:
            begin
                op = OP_DOWN;
            end
            OPC_UP:
            begin
                op = OP_UP;
            end
            OPC_NEXT:
            begin
                op          = OP_RECALL;
                slot_n      = adv_w;
                preset_next = adv_w[PW-1:0];
            end
            OPC_PREV:
            begin
                op          = OP_RECALL;
                slot_n      = prv_w;
                preset_next = prv_w[PW-1:0];
            end
            OPC_STORE:
            begin
                op          = OP_STORE;
                slot_n      = adv_w;
                preset_next = adv_w[PW-1:0];
            end
            OPC_RECALL:
            begin
                op     = OP_RECALL;
                slot_n = CW'(cmd.station);
                // recall of slot zero does nothing at all
                drop   = (cmd.station == 6'd0);
            end
            OPC_MUTE:
            begin
                op = OP_MUTE;
            end
            default:
            begin
                op = OP_STATUS;
            end
        endcase
        if (!accept)
        begin
            preset_next = preset_reg;
        end
    end

    assign q_push          = accept && !drop;
    assign q_entry.op      = op;
    assign q_entry.slot    = SLOT_W'(slot_n - CW'(1));
    assign q_entry.oob     = (slot_n > CW'(PRESET_SLOTS));
    assign q_entry.rx_data = cmd.rx_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preset_reg <= '0;
        end
        else
        begin
            preset_reg <= preset_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tpc_back.sv =====
// back end: keeps the tuning word and preset store, builds frames and status reports
// depends on tpc_pkg, tpc_rsp_if and tpc_ram
`default_nettype none

module tpc_back
    import tpc_pkg::*;
#(
    parameter int PRESET_SLOTS = 32,
    parameter int FREQ_STEP    = 10
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire q_entry_t head,
    input  wire logic     head_valid,
    output logic          pop,
    tpc_rsp_if.source     rsp
);

    localparam int AW = (PRESET_SLOTS > 1) ? $clog2(PRESET_SLOTS) : 1;
    localparam logic [15:0] STEP = 16'(FREQ_STEP);

    bk_state_t             state_reg;
    bk_state_t             state_next;
    logic [15:0]           freq_reg;
    logic [15:0]           freq_next;
    logic [PRESET_SLOTS-1:0] vld_reg;
    logic [PRESET_SLOTS-1:0] vld_next;
    logic                  hit_reg;
    logic                  oob_reg;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;
    logic                  load;
    logic                  emit;
    logic                  ram_wr_en;
    logic                  ram_rd_en;
    logic [AW-1:0]         addr;
    logic [15:0]           ram_rd_data;
    logic [15:0]           raw_word;
    logic [15:0]           recalled;

    function automatic logic [7:0] bit_rev(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic rsp_t freq_frame(input cfg_t c, input logic [15:0] f);
        rsp_t r;
        r            = '0;
        r.kind       = KIND_FRAME;
        r.mode_byte  = c.first_mode;
        r.data_one   = bit_rev(f[7:0]);
        r.data_two   = bit_rev(f[15:8]);
        r.data_three = FREQ_D3;
        r.last       = 1'b0;
        r.frequency  = f;
        return r;
    endfunction

    function automatic rsp_t ctrl_frame(input cfg_t c, input logic [7:0] d1,
                                        input logic [15:0] f);
        rsp_t r;
        r            = '0;
        r.kind       = KIND_FRAME;
        r.mode_byte  = c.second_mode;
        r.data_one   = d1;
        r.data_two   = CTRL_D2;
        r.data_three = CTRL_D3;
        r.last       = 1'b1;
        r.frequency  = f;
        return r;
    endfunction

    function automatic rsp_t status_rpt(input cfg_t c, input logic [23:0] rx,
                                        input logic [15:0] f);
        rsp_t r;
        r            = '0;
        r.kind       = KIND_STATUS;
        r.mode_byte  = c.read_mode;
        r.data_one   = rx[23:16];
        r.data_two   = rx[15:8];
        r.data_three = rx[7:0];
        r.last       = 1'b1;
        r.indicators = rx[23:20];
        r.if_count   = rx;
        r.frequency  = f;
        return r;
    endfunction

    assign addr = head.slot[AW-1:0];
    assign load = !rsp_valid_reg || rsp.ready;

    tpc_ram #(
        .WIDTH (16),
        .DEPTH (PRESET_SLOTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (addr),
        .wr_data (freq_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (addr),
        .rd_data (ram_rd_data)
    );

    // never-written slots and slots beyond the store read as zero; a word outside the band recalls as the bottom limit
    always_comb
    begin
        raw_word = (oob_reg || !hit_reg) ? 16'd0 : ram_rd_data;
        if (raw_word < cfg.freq_bottom || raw_word > cfg.freq_top)
        begin
            recalled = cfg.freq_bottom;
        end
        else
        begin
            recalled = raw_word;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        freq_next  = freq_reg;
        vld_next   = vld_reg;
        pop        = 1'b0;
        ram_wr_en  = 1'b0;
        ram_rd_en  = 1'b0;
        emit       = 1'b0;
        rsp_next   = rsp_reg;
        case (state_reg)
            BK_HEAD:
            begin
                if (head_valid)
                begin
                    case (head.op)
                        OP_DOWN:
                        begin
                            if (freq_reg > cfg.freq_bottom)
                            begin
                                if (load)
                                begin
                                    freq_next  = freq_reg - STEP;
                                    emit       = 1'b1;
                                    rsp_next   = freq_frame(cfg, freq_next);
                                    pop        = 1'b1;
                                    state_next = BK_SECOND;
                                end
                            end
                            else
                            begin
                                // wrap to the top limit, no frame
                                freq_next = cfg.freq_top;
                                pop       = 1'b1;
                            end
                        end
                        OP_UP:
                        begin
                            if (freq_reg < cfg.freq_top)
                            begin
                                if (load)
                                begin
                                    freq_next  = freq_reg + STEP;
                                    emit       = 1'b1;
                                    rsp_next   = freq_frame(cfg, freq_next);
                                    pop        = 1'b1;
                                    state_next = BK_SECOND;
                                end
                            end
                            else
                            begin
                                freq_next = cfg.freq_bottom;
                                pop       = 1'b1;
                            end
                        end
                        OP_STORE:
                        begin
                            ram_wr_en      = 1'b1;
                            vld_next[addr] = 1'b1;
                            pop            = 1'b1;
                        end
                        OP_RECALL:
                        begin
                            ram_rd_en  = 1'b1;
                            pop        = 1'b1;
                            state_next = BK_READ;
                        end
                        OP_MUTE:
                        begin
                            if (load)
                            begin
                                emit     = 1'b1;
                                rsp_next = ctrl_frame(cfg, cfg.mute_byte, freq_reg);
                                pop      = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (load)
                            begin
                                emit     = 1'b1;
                                rsp_next = status_rpt(cfg, head.rx_data, freq_reg);
                                pop      = 1'b1;
                            end
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                if (load)
                begin
                    freq_next  = recalled;
                    emit       = 1'b1;
                    rsp_next   = freq_frame(cfg, recalled);
                    state_next = BK_SECOND;
                end
            end
            BK_SECOND:
            begin
                if (load)
                begin
                    emit       = 1'b1;
                    rsp_next   = ctrl_frame(cfg, CTRL_D1, freq_reg);
                    state_next = BK_HEAD;
                end
            end
            default:
            begin
                state_next = BK_HEAD;
            end
        endcase
        rsp_valid_next = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_HEAD;
            freq_reg      <= 16'd0;
            vld_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            freq_reg      <= freq_next;
            vld_reg       <= vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (ram_rd_en)
        begin
            hit_reg <= vld_reg[addr];
            oob_reg <= head.oob;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.kind       = rsp_reg.kind;
    assign rsp.mode_byte  = rsp_reg.mode_byte;
    assign rsp.data_one   = rsp_reg.data_one;
    assign rsp.data_two   = rsp_reg.data_two;
    assign rsp.data_three = rsp_reg.data_three;
    assign rsp.last       = rsp_reg.last;
    assign rsp.indicators = rsp_reg.indicators;
    assign rsp.if_count   = rsp_reg.if_count;
    assign rsp.frequency  = rsp_reg.frequency;

endmodule

`default_nettype wire
